// ===== rtl/core/sorted_word_frequency_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted word frequency table
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_WORD_FREQUENCY_TABLE_TOP_ASSERT_SVH
`define SORTED_WORD_FREQUENCY_TABLE_TOP_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define SWFT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SWFT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/swft_pkg.sv =====
// ----------------------------------------------------------------------------
// swft_pkg
// Types, sizes and helpers shared by the sorted word frequency table.
// ----------------------------------------------------------------------------
package swft_pkg;

  localparam int Depth   = 128;
  localparam int KeyBits = 64;
  localparam int CntW    = 32;
  localparam int AddrW   = $clog2(Depth);
  localparam int UsedW   = $clog2(Depth + 1);

  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [UsedW-1:0]   used_t;
  typedef logic [KeyBits-1:0] key_t;
  typedef logic [CntW-1:0]    cnt_t;

  localparam cnt_t CntMax = '1;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRead   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StExisting = 3'd0,
    StInserted = 3'd1,
    StDropped  = 3'd2,
    StReadOk   = 3'd3,
    StReadOor  = 3'd4
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] key;
    logic [6:0]  index;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  position;
    logic [63:0] entry_key;
    logic [31:0] entry_count;
    logic [31:0] total_count;
    logic [7:0]  distinct_count;
  } out_item_t;

  // One table entry as held in memory.
  typedef struct packed {
    key_t key;
    cnt_t count;
  } entry_t;

  // Memory port request from the controller.
  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
  } mem_req_t;

  typedef enum logic [3:0] {
    SIdle,
    SSrchRd,
    SSrchCmp,
    SProbeCmp,
    SShiftRd,
    SShiftWr,
    SPlace,
    SReadRd,
    SReadCmp,
    SEmit
  } state_e;

  function automatic cnt_t sat_inc(cnt_t v);
    cnt_t r;
    r = (v == CntMax) ? v : v + cnt_t'(1);
    return r;
  endfunction

endpackage

// ===== rtl/core/swft_ram.sv =====
// ----------------------------------------------------------------------------
// swft_ram
// Entry memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module swft_ram (
  input  logic              clk_i,
  input  swft_pkg::mem_req_t req_i,
  output swft_pkg::entry_t   rd_data_o
);

  swft_pkg::entry_t mem_q [swft_pkg::Depth];
  swft_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/sorted_word_frequency_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_word_frequency_table_top
// Sorted key table with per-key occurrence counts, held in one entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one op per item:
//   insert a key, or read the entry at an index. out channel
//   (out_valid_o/out_ready_i/out_data_o) returns exactly one item per op.
//   Input is taken only while the controller is idle; one op is in work.
// Work per op, all through the entry memory (at most one access per state,
//   registered read data):
//   read op: one memory read in range; out of range goes straight to emit.
//   insert: a binary search step (read, compare) per halving (up to
//   log2(Depth)+1 steps), a probe of the found slot, then for a new key a
//   read and a write per entry moved up, then placing the key, then emit.
//   A hit, or a new key on a full table, goes straight to emit.
// Reset clears the entry and total counters; memory contents stay as they
//   are, since only entries below the entry count are ever read.
// A stalled receiver holds the finished item in the output register; the
//   next op may be accepted and worked while it waits, and its result waits
//   in the emit step until the output register frees.
// ----------------------------------------------------------------------------
`include "sorted_word_frequency_table_top_assert.svh"

module sorted_word_frequency_table_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swft_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swft_pkg::out_item_t  out_data_o
);

  swft_pkg::state_e    state_q, state_d;
  swft_pkg::key_t      key_q, key_d;
  logic [6:0]          idx_q, idx_d;
  swft_pkg::used_t     lo_q, lo_d;
  swft_pkg::used_t     hi_q, hi_d;
  swft_pkg::used_t     ptr_q, ptr_d;
  swft_pkg::used_t     used_q, used_d;
  swft_pkg::cnt_t      total_q, total_d;
  swft_pkg::out_item_t res_q, res_d;
  swft_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  swft_pkg::mem_req_t  mem_req;
  swft_pkg::entry_t    rd_data;

  logic                accept;
  logic                emit_fire;
  logic                full;
  logic [swft_pkg::UsedW:0] mid_sum;
  swft_pkg::used_t     mid;
  swft_pkg::cnt_t      hit_cnt;

  swft_ram u_ram (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  assign in_ready_o = (state_q == swft_pkg::SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign emit_fire  = (state_q == swft_pkg::SEmit) && (!out_valid_q || out_ready_i);
  assign full       = (used_q == swft_pkg::used_t'(swft_pkg::Depth));
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[swft_pkg::UsedW:1];
  assign hit_cnt    = swft_pkg::sat_inc(rd_data.count);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swft_pkg::SIdle: begin
        if (accept) begin
          if (in_data_i.op == swft_pkg::OpRead) begin
            state_d = ({1'b0, in_data_i.index} < used_q) ? swft_pkg::SReadRd : swft_pkg::SEmit;
          end else begin
            state_d = swft_pkg::SSrchRd;
          end
        end
      end
      swft_pkg::SSrchRd: begin
        if (lo_q < hi_q) begin
          state_d = swft_pkg::SSrchCmp;
        end else if (lo_q < used_q) begin
          state_d = swft_pkg::SProbeCmp;
        end else begin
          state_d = full ? swft_pkg::SEmit : swft_pkg::SShiftRd;
        end
      end
      swft_pkg::SSrchCmp: state_d = swft_pkg::SSrchRd;
      swft_pkg::SProbeCmp: begin
        if (rd_data.key == key_q || full) begin
          state_d = swft_pkg::SEmit;
        end else begin
          state_d = swft_pkg::SShiftRd;
        end
      end
      swft_pkg::SShiftRd: state_d = (ptr_q > lo_q) ? swft_pkg::SShiftWr : swft_pkg::SPlace;
      swft_pkg::SShiftWr: state_d = swft_pkg::SShiftRd;
      swft_pkg::SPlace:   state_d = swft_pkg::SEmit;
      swft_pkg::SReadRd:  state_d = swft_pkg::SReadCmp;
      swft_pkg::SReadCmp: state_d = swft_pkg::SEmit;
      swft_pkg::SEmit: begin
        if (emit_fire) begin
          state_d = swft_pkg::SIdle;
        end
      end
      default: state_d = swft_pkg::SIdle;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    key_d       = key_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ptr_d       = ptr_q;
    used_d      = used_q;
    total_d     = total_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_req     = '0;

    unique case (state_q)
      swft_pkg::SIdle: begin
        if (accept) begin
          key_d = swft_pkg::key_t'(in_data_i.key);
          idx_d = in_data_i.index;
          lo_d  = '0;
          hi_d  = used_q;
          ptr_d = used_q;
          // out of range read answers right away
          res_d          = '0;
          res_d.status   = swft_pkg::StReadOor;
          res_d.position = in_data_i.index;
        end
      end
      swft_pkg::SSrchRd: begin
        if (lo_q < hi_q) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = swft_pkg::addr_t'(mid);
        end else if (lo_q < used_q) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = swft_pkg::addr_t'(lo_q);
        end else if (full) begin
          res_d        = '0;
          res_d.status = swft_pkg::StDropped;
        end
      end
      swft_pkg::SSrchCmp: begin
        if (rd_data.key < key_q) begin
          lo_d = swft_pkg::used_t'(mid + 1'b1);
        end else begin
          hi_d = mid;
        end
      end
      swft_pkg::SProbeCmp: begin
        if (rd_data.key == key_q) begin
          mem_req.wr_en         = 1'b1;
          mem_req.wr_addr       = swft_pkg::addr_t'(lo_q);
          mem_req.wr_data.key   = key_q;
          mem_req.wr_data.count = hit_cnt;
          total_d               = swft_pkg::sat_inc(total_q);
          res_d.status          = swft_pkg::StExisting;
          res_d.position        = 7'(lo_q);
          res_d.entry_key       = 64'(key_q);
          res_d.entry_count     = hit_cnt;
        end else if (full) begin
          res_d        = '0;
          res_d.status = swft_pkg::StDropped;
        end
      end
      swft_pkg::SShiftRd: begin
        if (ptr_q > lo_q) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = swft_pkg::addr_t'(ptr_q - 1'b1);
        end
      end
      swft_pkg::SShiftWr: begin
        // move the entry below up one place
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = swft_pkg::addr_t'(ptr_q);
        mem_req.wr_data = rd_data;
        ptr_d           = ptr_q - 1'b1;
      end
      swft_pkg::SPlace: begin
        mem_req.wr_en         = 1'b1;
        mem_req.wr_addr       = swft_pkg::addr_t'(lo_q);
        mem_req.wr_data.key   = key_q;
        mem_req.wr_data.count = swft_pkg::cnt_t'(1);
        used_d                = used_q + 1'b1;
        total_d               = swft_pkg::sat_inc(total_q);
        res_d.status          = swft_pkg::StInserted;
        res_d.position        = 7'(lo_q);
        res_d.entry_key       = 64'(key_q);
        res_d.entry_count     = 32'(1);
      end
      swft_pkg::SReadRd: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = swft_pkg::addr_t'(idx_q);
      end
      swft_pkg::SReadCmp: begin
        res_d.status      = swft_pkg::StReadOk;
        res_d.position    = idx_q;
        res_d.entry_key   = 64'(rd_data.key);
        res_d.entry_count = rd_data.count;
      end
      swft_pkg::SEmit: ;
      default: ;
    endcase

    // output register: free on take, load on emit
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit_fire) begin
      out_d                = res_q;
      out_d.total_count    = total_q;
      out_d.distinct_count = 8'(used_q);
      out_valid_d          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swft_pkg::SIdle;
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    idx_q <= idx_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    ptr_q <= ptr_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SWFT_ASSERT_ALWAYS(a_used_in_range,
                      used_q <= swft_pkg::used_t'(swft_pkg::Depth),
                      "entry count above depth")
  `SWFT_ASSERT_IMPLIES(a_drop_only_full,
                       out_valid_o && out_data_o.status == swft_pkg::StDropped, full,
                       "key dropped while table had room")
  `SWFT_ASSERT_IMPLIES(a_shift_above_slot,
                       state_q == swft_pkg::SShiftWr, ptr_q > lo_q,
                       "shift wrote at or below insert slot")
  `SWFT_ASSERT_IMPLIES(a_one_access, mem_req.wr_en, !mem_req.rd_en,
                       "memory read and write in one cycle")

endmodule
